>>> sv/tcg_pkg.sv
// tcg_pkg: shared types and constants for the text console glyph renderer.
// Used by tcg_front, tcg_fifo, tcg_back and text_console_glyph_renderer.
// No dependencies.
package tcg_pkg;

  localparam int GLYPH_WIDTH = 8;

  localparam int WIDTH_W  = 14;
  localparam int HEIGHT_W = 13;
  localparam int COLOUR_W = 32;
  localparam int PIX_W    = 25;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int FIDX_W   = 12;
  localparam int FBYTE_W  = 8;
  localparam int MASK_W   = 8;
  localparam int LINE_W   = 13;
  localparam int COLS_W   = 11;
  localparam int ROWS_W   = 9;
  localparam int XS_W     = 12;
  localparam int PROD_W   = 27;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GLYPH  = 2'd2;
  localparam logic [1:0] REG_BG     = 2'd3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 14'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd768;
  localparam logic [COLOUR_W-1:0] GLYPH_RST  = 32'hFF00FFFF;
  localparam logic [COLOUR_W-1:0] BG_RST     = 32'hFF505050;

  typedef enum logic [1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_SCROLL = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_GLYPH = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_MOVE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width_px;
    logic [HEIGHT_W-1:0] height_px;
    logic [COLOUR_W-1:0] glyph_colour;
    logic [COLOUR_W-1:0] background_colour;
  } cfg_t;

  typedef struct packed {
    cmd_e               op;
    logic               scroll;
    logic [CHAR_W-1:0]  char_code;
    logic [FIDX_W-1:0]  font_index;
    logic [FBYTE_W-1:0] font_byte;
    logic [LINE_W-1:0]  line;
    logic [LINE_W-1:0]  xpx;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } cmd_t;

endpackage

>>> sv/tcg_front.sv
// tcg_front: accepts words, classifies them and tracks the text cursor.
// Emits one command per word into the command queue.
// Depends on tcg_pkg.
module tcg_front #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int TAB_STEP     = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcg_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [tcg_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcg_pkg::FIDX_W-1:0]   font_index_i,
  input  logic [tcg_pkg::FBYTE_W-1:0]  font_byte_i,
  input  logic                         full_i,
  output logic                         push_o,
  output tcg_pkg::cmd_t                cmd_o
);

  // height / GLYPH_HEIGHT as a reciprocal multiply, exact for every 13-bit height
  localparam int RowsShift = tcg_pkg::HEIGHT_W + $clog2(GLYPH_HEIGHT);
  localparam int RowsMul   = ((1 << RowsShift) + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;

  logic [tcg_pkg::COL_W-1:0]    col_q, col_d;
  logic [tcg_pkg::ROW_W-1:0]    row_q, row_d;
  logic [tcg_pkg::COLS_W-1:0]   cols_raw, cols;
  logic [tcg_pkg::HEIGHT_W-1:0] rows_raw;
  logic [31:0]                  rows_prod;
  logic [tcg_pkg::ROWS_W-1:0]   rows, ys;
  logic [tcg_pkg::XS_W-1:0]     xs, xw;
  logic [tcg_pkg::COL_W-1:0]    draw_col;
  tcg_pkg::cmd_e                op;
  logic                         wrap, yinc, scroll;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign cols_raw  = tcg_pkg::COLS_W'(cfg_i.width_px >> $clog2(tcg_pkg::GLYPH_WIDTH));
  assign cols      = (cols_raw == '0) ? tcg_pkg::COLS_W'(1) : cols_raw;
  assign rows_prod = 32'(cfg_i.height_px) * 32'(RowsMul);
  assign rows_raw  = tcg_pkg::HEIGHT_W'(rows_prod >> RowsShift);

  always_comb begin
    if (rows_raw == '0) begin
      rows = tcg_pkg::ROWS_W'(1);
    end else if (rows_raw > tcg_pkg::HEIGHT_W'(256)) begin
      rows = tcg_pkg::ROWS_W'(256);
    end else begin
      rows = rows_raw[tcg_pkg::ROWS_W-1:0];
    end
  end

  always_comb begin
    op       = tcg_pkg::CMD_MOVE;
    draw_col = col_q;
    wrap     = 1'b0;
    yinc     = 1'b0;
    xs       = tcg_pkg::XS_W'(col_q);
    if (char_code_i == tcg_pkg::CH_NEWLINE) begin
      xs   = '0;
      yinc = 1'b1;
    end else if (char_code_i == tcg_pkg::CH_RETURN) begin
      xs = '0;
    end else if (char_code_i == tcg_pkg::CH_TAB) begin
      xs   = tcg_pkg::XS_W'(col_q) + tcg_pkg::XS_W'(TAB_STEP);
      wrap = 1'b1;
    end else if (char_code_i == tcg_pkg::CH_BACKSPACE) begin
      if (col_q != '0) begin
        op       = tcg_pkg::CMD_FILL;
        draw_col = col_q - 1'b1;
        xs       = tcg_pkg::XS_W'(col_q) - tcg_pkg::XS_W'(1);
        wrap     = 1'b1;
      end
    end else begin
      op   = tcg_pkg::CMD_GLYPH;
      xs   = tcg_pkg::XS_W'(col_q) + tcg_pkg::XS_W'(1);
      wrap = 1'b1;
    end

    xw = xs;
    if (wrap && (xs >= tcg_pkg::XS_W'(cols))) begin
      xw = xs - tcg_pkg::XS_W'(cols);
      if (xw >= tcg_pkg::XS_W'(cols)) begin
        xw = '0;
      end
      yinc = 1'b1;
    end

    ys     = tcg_pkg::ROWS_W'(row_q);
    scroll = 1'b0;
    if (yinc) begin
      ys = tcg_pkg::ROWS_W'(row_q) + tcg_pkg::ROWS_W'(1);
      if (ys >= rows) begin
        scroll = 1'b1;
        ys     = rows - tcg_pkg::ROWS_W'(1);
      end
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o && (opcode_i == tcg_pkg::OP_PUT)) begin
      col_d = xw[tcg_pkg::COL_W-1:0];
      row_d = ys[tcg_pkg::ROW_W-1:0];
    end
  end

  always_comb begin
    cmd_o.op         = (opcode_i == tcg_pkg::OP_LOAD) ? tcg_pkg::CMD_LOAD : op;
    cmd_o.scroll     = (opcode_i == tcg_pkg::OP_PUT) && scroll;
    cmd_o.char_code  = char_code_i;
    cmd_o.font_index = font_index_i;
    cmd_o.font_byte  = font_byte_i;
    cmd_o.line       = tcg_pkg::LINE_W'(row_q * GLYPH_HEIGHT);
    cmd_o.xpx        = tcg_pkg::LINE_W'(draw_col) << $clog2(tcg_pkg::GLYPH_WIDTH);
    cmd_o.col        = col_d;
    cmd_o.row        = row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> sv/tcg_fifo.sv
// tcg_fifo: two-entry command queue between front and back.
// Depends on tcg_pkg.
module tcg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcg_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcg_pkg::cmd_t cmd_o
);

  tcg_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from empty queue");

endmodule

>>> sv/tcg_back.sv
// tcg_back: sequencer that turns commands into glyph rows, fills, scrolls and done words.
// Holds the glyph store; read data is aligned in a stage ahead of the output register.
// Depends on tcg_pkg.
module tcg_back #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcg_pkg::cfg_t                 cfg_i,
  input  logic                          q_valid_i,
  input  tcg_pkg::cmd_t                 q_cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [tcg_pkg::PIX_W-1:0]     pixel_index_o,
  output logic [tcg_pkg::MASK_W-1:0]    pixel_mask_o,
  output logic [tcg_pkg::COLOUR_W-1:0]  pixel_colour_o,
  output logic [tcg_pkg::COL_W-1:0]     cursor_col_out_o,
  output logic [tcg_pkg::ROW_W-1:0]     cursor_row_out_o,
  output logic                          last_o
);

  localparam int StoreSize = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int MemDepth  = (StoreSize > (1 << tcg_pkg::FIDX_W)) ?
                             (1 << tcg_pkg::FIDX_W) : StoreSize;
  localparam int AddrW     = $clog2(MemDepth);
  localparam int RowW      = $clog2(GLYPH_HEIGHT);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ROWS   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [tcg_pkg::FBYTE_W-1:0] mem [MemDepth];

  logic [1:0]                   state_q, state_d;
  tcg_pkg::cmd_t                cmd_q;
  logic [RowW-1:0]              r_q;
  logic [tcg_pkg::PIX_W-1:0]    pix_q;
  logic [tcg_pkg::LINE_W-1:0]   addr_q;
  logic [tcg_pkg::PROD_W-1:0]   prod;

  logic                         s1_v_q;
  tcg_pkg::kind_e               s1_kind_q, emit_kind;
  logic [tcg_pkg::PIX_W-1:0]    s1_pix_q;
  logic                         s1_rdok_q;
  logic [tcg_pkg::COL_W-1:0]    s1_col_q;
  logic [tcg_pkg::ROW_W-1:0]    s1_row_q;
  logic [tcg_pkg::FBYTE_W-1:0]  rd_q;

  logic                         out_v_q;
  tcg_pkg::kind_e               out_kind_q;
  logic [tcg_pkg::PIX_W-1:0]    out_pix_q, out_pix_d;
  logic [tcg_pkg::MASK_W-1:0]   out_mask_q, out_mask_d;
  logic [tcg_pkg::COLOUR_W-1:0] out_colour_q, out_colour_d;
  logic [tcg_pkg::COL_W-1:0]    out_col_q, out_col_d;
  logic [tcg_pkg::ROW_W-1:0]    out_row_q, out_row_d;
  logic                         out_last_q, out_last_d;

  logic out_adv, s1_adv, emit, row_step, row_end, do_write;

  assign out_adv  = !out_v_q || out_ready_i;
  assign s1_adv   = !s1_v_q || out_adv;
  assign pop_o    = q_valid_i && ((state_q == S_IDLE) || ((state_q == S_DONE) && s1_adv));
  assign emit     = s1_adv && (state_q != S_IDLE);
  assign row_step = s1_adv && (state_q == S_ROWS);
  assign row_end  = (r_q == RowW'(GLYPH_HEIGHT - 1));
  assign do_write = pop_o && (q_cmd_i.op == tcg_pkg::CMD_LOAD) &&
                    (tcg_pkg::LINE_W'(q_cmd_i.font_index) < tcg_pkg::LINE_W'(MemDepth));
  assign prod     = tcg_pkg::PROD_W'(q_cmd_i.line) * tcg_pkg::PROD_W'(cfg_i.width_px);

  always_comb begin
    case (state_q)
      S_ROWS:   emit_kind = (cmd_q.op == tcg_pkg::CMD_FILL) ?
                            tcg_pkg::KIND_FILL : tcg_pkg::KIND_GLYPH;
      S_SCROLL: emit_kind = tcg_pkg::KIND_SCROLL;
      default:  emit_kind = tcg_pkg::KIND_DONE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   state_d = S_IDLE;
      S_ROWS: begin
        if (s1_adv && row_end) begin
          state_d = cmd_q.scroll ? S_SCROLL : S_DONE;
        end
      end
      S_SCROLL: if (s1_adv) state_d = S_DONE;
      S_DONE:   if (s1_adv) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    if (pop_o) begin
      case (q_cmd_i.op)
        tcg_pkg::CMD_GLYPH, tcg_pkg::CMD_FILL: state_d = S_ROWS;
        tcg_pkg::CMD_MOVE: state_d = q_cmd_i.scroll ? S_SCROLL : S_DONE;
        default:           state_d = S_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s1_adv) begin
        s1_v_q <= emit;
      end
      if (out_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= q_cmd_i;
      r_q    <= '0;
      pix_q  <= prod[tcg_pkg::PIX_W-1:0] + tcg_pkg::PIX_W'(q_cmd_i.xpx);
      addr_q <= tcg_pkg::LINE_W'(q_cmd_i.char_code * GLYPH_HEIGHT);
    end else if (row_step) begin
      r_q    <= r_q + 1'b1;
      pix_q  <= pix_q + tcg_pkg::PIX_W'(cfg_i.width_px);
      addr_q <= addr_q + 1'b1;
    end
  end

  // glyph store: one write port for loads, one registered read port for rows
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[q_cmd_i.font_index[AddrW-1:0]] <= q_cmd_i.font_byte;
    end
    if (row_step) begin
      rd_q <= mem[addr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_kind_q <= emit_kind;
      s1_pix_q  <= (state_q == S_ROWS) ? pix_q : '0;
      s1_rdok_q <= (addr_q < tcg_pkg::LINE_W'(MemDepth));
      s1_col_q  <= cmd_q.col;
      s1_row_q  <= cmd_q.row;
    end
  end

  always_comb begin
    out_pix_d    = '0;
    out_mask_d   = '0;
    out_colour_d = '0;
    out_col_d    = '0;
    out_row_d    = '0;
    out_last_d   = 1'b0;
    case (s1_kind_q)
      tcg_pkg::KIND_GLYPH: begin
        out_pix_d    = s1_pix_q;
        out_mask_d   = s1_rdok_q ? rd_q : '0;
        out_colour_d = cfg_i.glyph_colour;
      end
      tcg_pkg::KIND_FILL: begin
        out_pix_d    = s1_pix_q;
        out_mask_d   = '1;
        out_colour_d = cfg_i.background_colour;
      end
      tcg_pkg::KIND_SCROLL: begin
        out_colour_d = cfg_i.background_colour;
      end
      default: begin
        out_col_d  = s1_col_q;
        out_row_d  = s1_row_q;
        out_last_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_v_q) begin
      out_kind_q   <= s1_kind_q;
      out_pix_q    <= out_pix_d;
      out_mask_q   <= out_mask_d;
      out_colour_q <= out_colour_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign kind_o           = out_kind_q;
  assign pixel_index_o    = out_pix_q;
  assign pixel_mask_o     = out_mask_q;
  assign pixel_colour_o   = out_colour_q;
  assign cursor_col_out_o = out_col_q;
  assign cursor_row_out_o = out_row_q;
  assign last_o           = out_last_q;

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE || state_q == S_DONE))
    else $error("command taken while sequencer busy");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROWS) |-> (r_q <= RowW'(GLYPH_HEIGHT - 1)))
    else $error("row counter out of range");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_adv) |=> (s1_v_q && $stable(s1_kind_q) && $stable(rd_q)))
    else $error("read stage lost data under stall");

endmodule

>>> sv/text_console_glyph_renderer.sv
// text_console_glyph_renderer: top level with the APB register file.
// Instantiates tcg_front, tcg_fifo and tcg_back; depends on tcg_pkg.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   opcode_i char_code_i font_index_i font_byte_i
//   out      out_valid_o / out_ready_i kind_o pixel_index_o pixel_mask_o pixel_colour_o
//                                      cursor_col_out_o cursor_row_out_o last_o
//   cfg      psel penable pwrite pready paddr pwdata prdata
//
// Put of a printable char, or backspace off column zero: GLYPH_HEIGHT row words, then
// a scroll word with scroll, then a done word. Newline, return, tab, backspace at
// column zero: a scroll word with scroll, then a done word; load: a done word. The
// back sequencer emits one result word per cycle unless the output stalls.
// A two-entry command queue lets the front accept while the back is drawing.
// Reset clears the cursor and loads the registers with their reset values; the glyph store is not cleared.
// Output stalls back up through the sequencer into the queue and then in_ready_o.
module text_console_glyph_renderer #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256,
  parameter int TAB_STEP     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcg_pkg::APB_AW-1:0]     paddr,
  input  logic [tcg_pkg::APB_DW-1:0]     pwdata,
  output logic [tcg_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [tcg_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcg_pkg::FIDX_W-1:0]     font_index_i,
  input  logic [tcg_pkg::FBYTE_W-1:0]    font_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [tcg_pkg::PIX_W-1:0]      pixel_index_o,
  output logic [tcg_pkg::MASK_W-1:0]     pixel_mask_o,
  output logic [tcg_pkg::COLOUR_W-1:0]   pixel_colour_o,
  output logic [tcg_pkg::COL_W-1:0]      cursor_col_out_o,
  output logic [tcg_pkg::ROW_W-1:0]      cursor_row_out_o,
  output logic                           last_o
);

  tcg_pkg::cfg_t cfg_q;
  tcg_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, full, q_valid, wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_px          <= tcg_pkg::WIDTH_RST;
      cfg_q.height_px         <= tcg_pkg::HEIGHT_RST;
      cfg_q.glyph_colour      <= tcg_pkg::GLYPH_RST;
      cfg_q.background_colour <= tcg_pkg::BG_RST;
    end else if (wr_en) begin
      case (reg_sel)
        tcg_pkg::REG_WIDTH:  cfg_q.width_px <= pwdata[tcg_pkg::WIDTH_W-1:0];
        tcg_pkg::REG_HEIGHT: cfg_q.height_px <= pwdata[tcg_pkg::HEIGHT_W-1:0];
        tcg_pkg::REG_GLYPH:  cfg_q.glyph_colour <= pwdata;
        default:             cfg_q.background_colour <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tcg_pkg::REG_WIDTH:  prdata = tcg_pkg::APB_DW'(cfg_q.width_px);
      tcg_pkg::REG_HEIGHT: prdata = tcg_pkg::APB_DW'(cfg_q.height_px);
      tcg_pkg::REG_GLYPH:  prdata = cfg_q.glyph_colour;
      default:             prdata = cfg_q.background_colour;
    endcase
  end

  tcg_front #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .TAB_STEP     (TAB_STEP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .font_index_i (font_index_i),
    .font_byte_i  (font_byte_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  tcg_back #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_cmd_i          (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .pixel_index_o    (pixel_index_o),
    .pixel_mask_o     (pixel_mask_o),
    .pixel_colour_o   (pixel_colour_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_row_out_o (cursor_row_out_o),
    .last_o           (last_o)
  );

endmodule
